@@ hdl/cspid_pkg.sv @@
// ----------------------------------------------------------------------------
// cspid_pkg
// Shared types, register indexes and arithmetic helpers for the cascaded
// speed/current PID controller.
// ----------------------------------------------------------------------------
package cspid_pkg;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED_KP      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED_KI      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED_KD      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_CURRENT_KP    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CURRENT_KI    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_CURRENT_KD    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_CURRENT_LIMIT = 3'd6;

  localparam int CFG_DATA_W     = 16;
  localparam int LIMIT_W        = 15;
  localparam int LIMIT_RESET    = 1000;

  // Datapath widths
  localparam int ERR_W   = 18;   // speed / current error
  localparam int DIFF_W  = 19;   // first and second differences
  localparam int MUL_A_W = 16;   // gain operand
  localparam int MUL_B_W = 32;   // signal operand
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int SUM_W   = 50;   // sum of three floored products
  localparam int WIDE_W  = 51;   // accumulator update before saturation

  // Drive limits
  localparam int DRIVE_W       = 11;
  localparam int PWM_W         = 10;
  localparam int DRIVE_MAX     = 996;
  localparam int DRIVE_MIN_MAG = 3;

  // Datapath operations, one per controller step
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIFF,
    OP_SP_P,
    OP_SP_I,
    OP_SP_D,
    OP_SP_ACC,
    OP_SP_UPD,
    OP_CU_ERR,
    OP_CU_P,
    OP_CU_I,
    OP_CU_D,
    OP_CU_ACC,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic all_one;
    logic all_zero;
    all_one  = &v[WIDE_W-1:31];
    all_zero = ~|v[WIDE_W-1:31];
    if (all_one || all_zero) begin
      return v[31:0];
    end else if (v[WIDE_W-1]) begin
      return 32'sh8000_0000;
    end else begin
      return 32'sh7FFF_FFFF;
    end
  endfunction

endpackage

@@ hdl/cspid_ctrl.sv @@
// ----------------------------------------------------------------------------
// cspid_ctrl
// Step sequencer for one control tick and the output valid flag.
// ----------------------------------------------------------------------------
module cspid_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output cspid_pkg::dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SP_P,
    ST_SP_I,
    ST_SP_D,
    ST_SP_ACC,
    ST_SP_UPD,
    ST_CU_ERR,
    ST_CU_P,
    ST_CU_I,
    ST_CU_D,
    ST_CU_ACC,
    ST_OUT
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Command decode and next state
  always_comb begin
    cmd.op     = cspid_pkg::OP_NONE;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = cspid_pkg::OP_LOAD;
          state_next = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd.op = cspid_pkg::OP_DIFF;   state_next = ST_SP_P;
      end
      ST_SP_P: begin
        cmd.op = cspid_pkg::OP_SP_P;   state_next = ST_SP_I;
      end
      ST_SP_I: begin
        cmd.op = cspid_pkg::OP_SP_I;   state_next = ST_SP_D;
      end
      ST_SP_D: begin
        cmd.op = cspid_pkg::OP_SP_D;   state_next = ST_SP_ACC;
      end
      ST_SP_ACC: begin
        cmd.op = cspid_pkg::OP_SP_ACC; state_next = ST_SP_UPD;
      end
      ST_SP_UPD: begin
        cmd.op = cspid_pkg::OP_SP_UPD; state_next = ST_CU_ERR;
      end
      ST_CU_ERR: begin
        cmd.op = cspid_pkg::OP_CU_ERR; state_next = ST_CU_P;
      end
      ST_CU_P: begin
        cmd.op = cspid_pkg::OP_CU_P;   state_next = ST_CU_I;
      end
      ST_CU_I: begin
        cmd.op = cspid_pkg::OP_CU_I;   state_next = ST_CU_D;
      end
      ST_CU_D: begin
        cmd.op = cspid_pkg::OP_CU_D;   state_next = ST_CU_ACC;
      end
      ST_CU_ACC: begin
        cmd.op = cspid_pkg::OP_CU_ACC; state_next = ST_OUT;
      end
      ST_OUT: begin
        // wait here while the output register still holds an untaken item
        if (out_free) begin
          cmd.op     = cspid_pkg::OP_OUT;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.op == cspid_pkg::OP_OUT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hdl/cspid_datapath.sv @@
// ----------------------------------------------------------------------------
// cspid_datapath
// Gain registers, loop state, one shared 16x32 multiplier with a registered
// product, the summing register and the output register.
// ----------------------------------------------------------------------------
module cspid_datapath #(
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  cspid_pkg::dp_cmd_t                          cmd,
  input  logic                                        cfg_write,
  input  logic [cspid_pkg::CFG_INDEX_W-1:0]           cfg_index,
  input  logic [cspid_pkg::CFG_DATA_W-1:0]            cfg_data,
  input  logic signed [15:0]                          speed_target,
  input  logic [15:0]                                 encoder_count,
  input  logic signed [15:0]                          current_measured,
  output logic signed [cspid_pkg::DRIVE_W-1:0]        drive,
  output logic [cspid_pkg::PWM_W-1:0]                 pwm_forward,
  output logic [cspid_pkg::PWM_W-1:0]                 pwm_reverse,
  output logic signed [15:0]                          current_target
);

  localparam int ERR_W  = cspid_pkg::ERR_W;
  localparam int DIFF_W = cspid_pkg::DIFF_W;
  localparam int SUM_W  = cspid_pkg::SUM_W;
  localparam int WIDE_W = cspid_pkg::WIDE_W;
  localparam int DW     = cspid_pkg::DRIVE_W;

  localparam logic signed [SUM_W-1:0] DRV_HI     = SUM_W'(cspid_pkg::DRIVE_MAX);
  localparam logic signed [SUM_W-1:0] DRV_LO     = -DRV_HI;
  localparam logic signed [SUM_W-1:0] DRV_MAG_HI = SUM_W'(cspid_pkg::DRIVE_MIN_MAG);
  localparam logic signed [SUM_W-1:0] DRV_MAG_LO = -DRV_MAG_HI;

  // Configuration
  logic signed [15:0]                    speed_kp, speed_ki, speed_kd;
  logic signed [15:0]                    current_kp, current_ki, current_kd;
  logic [cspid_pkg::LIMIT_W-1:0]         current_limit;

  // Loop state
  logic [15:0]                           encoder_previous;
  logic signed [ERR_W-1:0]               speed_error_last;
  logic signed [ERR_W-1:0]               speed_error_before_last;
  logic signed [31:0]                    speed_accumulator;
  logic signed [ERR_W-1:0]               current_error_last;
  logic signed [31:0]                    current_error_sum;

  // Working registers
  logic signed [ERR_W-1:0]               err;
  logic signed [15:0]                    imeas;
  logic signed [DIFF_W-1:0]              d1, d2, cdiff;
  logic signed [ERR_W-1:0]               ie;
  logic signed [15:0]                    itarget;
  logic signed [cspid_pkg::PROD_W-1:0]   prod;
  logic signed [SUM_W-1:0]               sum;

  // Combinational
  logic signed [15:0]                    speed_diff;
  logic signed [ERR_W-1:0]               err_next;
  logic signed [cspid_pkg::MUL_A_W-1:0]  mul_a;
  logic signed [cspid_pkg::MUL_B_W-1:0]  mul_b;
  logic signed [cspid_pkg::PROD_W-1:0]   prod_next;
  logic signed [SUM_W-1:0]               term;
  logic signed [31:0]                    lim32;
  logic signed [15:0]                    lim16;
  logic signed [15:0]                    itarget_next;
  logic signed [DW-1:0]                  drive_next;
  logic signed [DW-1:0]                  drive_neg;

  // Speed from wrapped count difference, then speed error
  assign speed_diff = $signed(encoder_count - encoder_previous);
  assign err_next   = ERR_W'(speed_target) - ERR_W'(speed_diff);

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      cspid_pkg::OP_SP_P: begin mul_a = speed_kp;   mul_b = 32'(d1);    end
      cspid_pkg::OP_SP_I: begin mul_a = speed_ki;   mul_b = 32'(err);   end
      cspid_pkg::OP_SP_D: begin mul_a = speed_kd;   mul_b = 32'(d2);    end
      cspid_pkg::OP_CU_P: begin mul_a = current_kp; mul_b = 32'(ie);    end
      cspid_pkg::OP_CU_I: begin mul_a = current_ki; mul_b = current_error_sum; end
      cspid_pkg::OP_CU_D: begin mul_a = current_kd; mul_b = 32'(cdiff); end
      default: begin end
    endcase
  end

  assign prod_next = mul_a * mul_b;

  // Floored product of the previous step
  assign term = SUM_W'(prod >>> GAIN_FRAC_BITS);

  // Current target clamp
  assign lim16 = $signed({1'b0, current_limit});
  assign lim32 = 32'(lim16);
  always_comb begin
    if (speed_accumulator > lim32) begin
      itarget_next = lim16;
    end else if (speed_accumulator < -lim32) begin
      itarget_next = -lim16;
    end else begin
      itarget_next = speed_accumulator[15:0];
    end
  end

  // Drive clamp with minimum magnitude
  always_comb begin
    if (sum > DRV_HI) begin
      drive_next = DW'(DRV_HI);
    end else if (sum >= 0 && sum < DRV_MAG_HI) begin
      drive_next = DW'(DRV_MAG_HI);
    end else if (sum < DRV_LO) begin
      drive_next = DW'(DRV_LO);
    end else if (sum < 0 && sum > DRV_MAG_LO) begin
      drive_next = DW'(DRV_MAG_LO);
    end else begin
      drive_next = sum[DW-1:0];
    end
  end
  assign drive_neg = -drive_next;

  // Configuration and loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      speed_kp                <= '0;
      speed_ki                <= '0;
      speed_kd                <= '0;
      current_kp              <= '0;
      current_ki              <= '0;
      current_kd              <= '0;
      current_limit           <= cspid_pkg::LIMIT_W'(cspid_pkg::LIMIT_RESET);
      encoder_previous        <= '0;
      speed_error_last        <= '0;
      speed_error_before_last <= '0;
      speed_accumulator       <= '0;
      current_error_last      <= '0;
      current_error_sum       <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          cspid_pkg::REG_SPEED_KP:      speed_kp   <= $signed(cfg_data);
          cspid_pkg::REG_SPEED_KI:      speed_ki   <= $signed(cfg_data);
          cspid_pkg::REG_SPEED_KD:      speed_kd   <= $signed(cfg_data);
          cspid_pkg::REG_CURRENT_KP:    current_kp <= $signed(cfg_data);
          cspid_pkg::REG_CURRENT_KI:    current_ki <= $signed(cfg_data);
          cspid_pkg::REG_CURRENT_KD:    current_kd <= $signed(cfg_data);
          cspid_pkg::REG_CURRENT_LIMIT: current_limit <= cfg_data[cspid_pkg::LIMIT_W-1:0];
          default: begin end
        endcase
      end
      unique case (cmd.op)
        cspid_pkg::OP_LOAD: encoder_previous <= encoder_count;
        cspid_pkg::OP_DIFF: begin
          speed_error_before_last <= speed_error_last;
          speed_error_last        <= err;
        end
        cspid_pkg::OP_SP_UPD:
          speed_accumulator <= cspid_pkg::sat32(WIDE_W'(speed_accumulator) + WIDE_W'(sum));
        cspid_pkg::OP_CU_P: begin
          current_error_sum  <= cspid_pkg::sat32(WIDE_W'(current_error_sum) + WIDE_W'(ie));
          current_error_last <= ie;
        end
        default: begin end
      endcase
    end
  end

  // Working registers and output register
  always_ff @(posedge clk) begin
    prod <= prod_next;
    unique case (cmd.op)
      cspid_pkg::OP_LOAD: begin
        err   <= err_next;
        imeas <= current_measured;
      end
      cspid_pkg::OP_DIFF: begin
        d1 <= DIFF_W'(err) - DIFF_W'(speed_error_last);
        d2 <= DIFF_W'(err) - (DIFF_W'(speed_error_last) <<< 1)
              + DIFF_W'(speed_error_before_last);
      end
      cspid_pkg::OP_SP_I:   sum <= term;
      cspid_pkg::OP_SP_D:   sum <= sum + term;
      cspid_pkg::OP_SP_ACC: sum <= sum + term;
      cspid_pkg::OP_CU_ERR: begin
        itarget <= itarget_next;
        ie      <= ERR_W'(itarget_next) - ERR_W'(imeas);
      end
      cspid_pkg::OP_CU_P:   cdiff <= DIFF_W'(ie) - DIFF_W'(current_error_last);
      cspid_pkg::OP_CU_I:   sum <= term;
      cspid_pkg::OP_CU_D:   sum <= sum + term;
      cspid_pkg::OP_CU_ACC: sum <= sum + term;
      cspid_pkg::OP_OUT: begin
        drive          <= drive_next;
        pwm_forward    <= (drive_next > 0) ? drive_next[cspid_pkg::PWM_W-1:0] : '0;
        pwm_reverse    <= (drive_next < 0) ? drive_neg[cspid_pkg::PWM_W-1:0] : '0;
        current_target <= itarget;
      end
      default: begin end
    endcase
  end

endmodule

@@ hdl/cascaded_speed_current_pid_top.sv @@
// ----------------------------------------------------------------------------
// cascaded_speed_current_pid_top
// Cascaded speed/current PID controller for a brushed motor.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one control tick: speed target,
//   raw encoder count and measured current. Output channel
//   (out_valid/out_stall) returns drive, forward/reverse PWM compare values
//   and the clamped current target for that tick.
//   Gains and the current limit are written on cfg_write/cfg_index/cfg_data
//   while no tick is in flight.
// Sequencing:
//   An item passes through the accept edge plus 12 sequencer steps, six of
//   them passes through the one shared 16x32 multiplier. The result is in
//   the output register once the OUT step has run; the next item is taken
//   in the cycle after that.
//   in_stall is low only while the sequencer is idle; an item may be taken
//   while the previous result still waits in the output register.
//   If the receiver stalls, the result holds, and a following item finishes
//   its work and then waits until the output register is free.
// Reset: rst clears gains to 0, current limit to 1000, all loop state to 0.
// ----------------------------------------------------------------------------
module cascaded_speed_current_pid_top #(
  parameter int GAIN_FRAC_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [cspid_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [cspid_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [15:0]                    speed_target,
  input  logic [15:0]                           encoder_count,
  input  logic signed [15:0]                    current_measured,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [cspid_pkg::DRIVE_W-1:0]  drive,
  output logic [cspid_pkg::PWM_W-1:0]           pwm_forward,
  output logic [cspid_pkg::PWM_W-1:0]           pwm_reverse,
  output logic signed [15:0]                    current_target
);

  cspid_pkg::dp_cmd_t cmd;

  // Step sequencer
  cspid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Arithmetic and state
  cspid_datapath #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .speed_target     (speed_target),
    .encoder_count    (encoder_count),
    .current_measured (current_measured),
    .drive            (drive),
    .pwm_forward      (pwm_forward),
    .pwm_reverse      (pwm_reverse),
    .current_target   (current_target)
  );

endmodule

@@ hdl/cspid_checker.sv @@
// ----------------------------------------------------------------------------
// cspid_checker
// Port-level checks for the cascaded speed/current PID controller.
// ----------------------------------------------------------------------------
module cspid_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [cspid_pkg::DRIVE_W-1:0]  drive,
  input logic [cspid_pkg::PWM_W-1:0]           pwm_forward,
  input logic [cspid_pkg::PWM_W-1:0]           pwm_reverse
);

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(drive))
    else $error("output item changed while stalled");

  // The sequencer is busy in the cycle after an item is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after an accept");

  // Drive never reads zero while out_valid is high
  a_drive_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> drive != 0)
    else $error("drive is zero");

  // PWM split follows the drive sign
  a_pwm_split: assert property (@(posedge clk) disable iff (rst)
    out_valid && !drive[cspid_pkg::DRIVE_W-1] |->
      pwm_reverse == 0 && pwm_forward == drive[cspid_pkg::PWM_W-1:0])
    else $error("forward PWM does not match a positive drive");

  a_pwm_rev: assert property (@(posedge clk) disable iff (rst)
    out_valid && drive[cspid_pkg::DRIVE_W-1] |-> pwm_forward == 0 && pwm_reverse != 0)
    else $error("reverse PWM does not match a negative drive");

endmodule

bind cascaded_speed_current_pid_top cspid_checker u_cspid_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .drive       (drive),
  .pwm_forward (pwm_forward),
  .pwm_reverse (pwm_reverse)
);
